FILE: src/efnf_pkg.sv
// Shared types and constants for the ENU/FLU to NED/FRD pose converter.
`default_nettype none
package efnf_pkg;
  localparam int unsigned LANES   = 4;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ATT_W   = 16;
  localparam int unsigned MAG_W   = 17;  // |v_i| <= 2^16
  localparam int unsigned SQR_W   = 33;  // v_i^2 <= 2^32
  localparam int unsigned SUM_W   = 35;  // sum of squares <= 2^34
  localparam int unsigned REM_W   = 36;  // doubled remainder stays below 2^35
  localparam int unsigned QUO_W   = 31;  // quotient <= 2^30
  localparam int unsigned RT_W    = 32;  // root iteration registers
  localparam int unsigned DIV_N   = QUO_W;
  localparam int unsigned SQ_N    = 16;
  localparam logic [ATT_W-1:0] Q14_ONE = 16'd16384;

  typedef struct packed {
    logic [POS_W-1:0] north;
    logic [POS_W-1:0] east;
    logic [POS_W-1:0] down;
    logic [LANES-1:0] neg;
    logic             zero;
  } side_t;
endpackage
`default_nettype wire

FILE: src/enu_flu_to_ned_frd_pose_core.sv
// ENU/FLU pose to NED/FRD pose converter, fully pipelined.
//
// Usage: one input word carries an ENU position (Q16.16) and an ENU-from-FLU
// quaternion (Q2.14); one output word carries the NED position and the
// normalized NED-from-FRD quaternion with non-negative scalar part.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The block takes one word per clock cycle unless the output stalls.
// The pipeline has 51 register stages: three stages form the turned vector
// and its sum of squares, 31 stages do a restoring divide (one quotient bit
// each), 16 stages do the integer square root (one root bit each), and one
// stage rounds into the output register.
// When the receiver stalls with a word waiting at the output, the whole
// pipeline holds and stall_o is raised toward the sender; nothing is lost.
// Reset clears all valid bits; the pipeline is then empty and ready.
`default_nettype none
module enu_flu_to_ned_frd_pose_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] pos_east_i,
  input  wire logic [31:0] pos_north_i,
  input  wire logic [31:0] pos_up_i,
  input  wire logic [15:0] att_w_in_i,
  input  wire logic [15:0] att_x_in_i,
  input  wire logic [15:0] att_y_in_i,
  input  wire logic [15:0] att_z_in_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic             pose_valid_o,
  output logic [31:0]      ned_north_o,
  output logic [31:0]      ned_east_o,
  output logic [31:0]      ned_down_o,
  output logic [15:0]      att_w_out_o,
  output logic [15:0]      att_x_out_o,
  output logic [15:0]      att_y_out_o,
  output logic [15:0]      att_z_out_o
);
  localparam int unsigned LN    = efnf_pkg::LANES;
  localparam int unsigned DIV0  = 3;
  localparam int unsigned SQ0   = DIV0 + efnf_pkg::DIV_N;
  localparam int unsigned T     = SQ0 + efnf_pkg::SQ_N + 1;

  logic                          adv;
  logic [T-1:0]                  vld_q;
  efnf_pkg::side_t               side_q [T];

  logic [efnf_pkg::MAG_W-1:0]    mag_d [LN];
  logic [efnf_pkg::MAG_W-1:0]    mag_q [LN];
  logic [efnf_pkg::SQR_W-1:0]    sqr_q [LN];
  logic [efnf_pkg::SQR_W-1:0]    sqr3_q [LN];
  logic [efnf_pkg::SUM_W-1:0]    sum_q;
  logic [efnf_pkg::SUM_W-1:0]    sum_d;
  efnf_pkg::side_t               side0_d;
  efnf_pkg::side_t               side2_d;

  logic [efnf_pkg::REM_W-1:0]    rem_q [efnf_pkg::DIV_N][LN];
  logic [efnf_pkg::QUO_W-1:0]    quo_q [efnf_pkg::DIV_N][LN];
  logic [efnf_pkg::SUM_W-1:0]    dsr_q [efnf_pkg::DIV_N];

  logic [efnf_pkg::RT_W-1:0]     rn_q  [efnf_pkg::SQ_N][LN];
  logic [efnf_pkg::RT_W-1:0]     rr_q  [efnf_pkg::SQ_N][LN];

  logic [efnf_pkg::ATT_W-1:0]    att_d [LN];
  logic [efnf_pkg::ATT_W-1:0]    att_q [LN];

  // Advance everything unless a finished word is held at the output
  assign adv     = !(vld_q[T-1] && stall_i);
  assign stall_o = !adv;

  // Turn the quaternion, apply the sign rule, take magnitudes; negate up
  always_comb begin
    logic signed [17:0] w, x, y, z;
    logic signed [17:0] v [LN];
    logic signed [32:0] dn;
    logic               flip;
    w = 18'(signed'(att_w_in_i));
    x = 18'(signed'(att_x_in_i));
    y = 18'(signed'(att_y_in_i));
    z = 18'(signed'(att_z_in_i));
    v[0] = -(w + z);
    v[1] = -(x + y);
    v[2] = y - x;
    v[3] = z - w;
    flip = v[0][17];
    for (int l = 0; l < LN; l++) begin
      if (flip) v[l] = -v[l];
      side0_d.neg[l] = v[l][17];
      mag_d[l] = v[l][17] ? efnf_pkg::MAG_W'(-v[l]) : efnf_pkg::MAG_W'(v[l]);
    end
    dn = -33'(signed'(pos_up_i));
    side0_d.down  = (dn > 33'sd2147483647) ? 32'h7fff_ffff : dn[31:0];
    side0_d.north = pos_north_i;
    side0_d.east  = pos_east_i;
    side0_d.zero  = 1'b0;
  end

  // Sum the squares
  always_comb begin
    sum_d = '0;
    for (int l = 0; l < LN; l++) sum_d = sum_d + efnf_pkg::SUM_W'(sqr_q[l]);
  end

  // Mark the zero vector alongside the sum
  always_comb begin
    side2_d      = side_q[1];
    side2_d.zero = (sum_d == '0);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[T-2:0], valid_i};
    end
  end

  // Front stages: magnitude, square, sum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side0_d;
      side_q[1] <= side_q[0];
      side_q[2] <= side2_d;
      sum_q <= sum_d;
      for (int l = 0; l < LN; l++) begin
        mag_q[l]  <= mag_d[l];
        sqr_q[l]  <= efnf_pkg::SQR_W'(mag_q[l]) * efnf_pkg::SQR_W'(mag_q[l]);
        sqr3_q[l] <= sqr_q[l];
      end
    end
  end

  // Side data rides along with the arithmetic stages
  for (genvar i = 3; i < T; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) side_q[i] <= side_q[i-1];
    end
  end

  // Restoring divide of v_i^2 * 2^30 by the sum, one quotient bit a stage
  for (genvar j = 0; j < efnf_pkg::DIV_N; j++) begin : g_div
    logic [efnf_pkg::REM_W-1:0] rem_d [LN];
    logic [efnf_pkg::QUO_W-1:0] quo_d [LN];
    logic [efnf_pkg::SUM_W-1:0] dsr;
    always_comb begin
      logic [efnf_pkg::REM_W-1:0] t;
      logic                       qb;
      dsr = (j == 0) ? sum_q : dsr_q[(j == 0) ? 0 : j-1];
      for (int l = 0; l < LN; l++) begin
        if (j == 0) begin
          t = efnf_pkg::REM_W'(sqr3_q[l]);
          quo_d[l] = '0;
        end else begin
          t = {rem_q[(j == 0) ? 0 : j-1][l][efnf_pkg::REM_W-2:0], 1'b0};
          quo_d[l] = quo_q[(j == 0) ? 0 : j-1][l];
        end
        qb = (t >= efnf_pkg::REM_W'(dsr));
        rem_d[l] = qb ? t - efnf_pkg::REM_W'(dsr) : t;
        quo_d[l] = {quo_d[l][efnf_pkg::QUO_W-2:0], qb};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dsr_q[j] <= dsr;
        for (int l = 0; l < LN; l++) begin
          rem_q[j][l] <= rem_d[l];
          quo_q[j][l] <= quo_d[l];
        end
      end
    end
  end

  // Integer square root of the quotient, one root bit a stage
  for (genvar k = 0; k < efnf_pkg::SQ_N; k++) begin : g_sqrt
    localparam logic [efnf_pkg::RT_W-1:0] BIT =
      efnf_pkg::RT_W'(1) << (2 * (efnf_pkg::SQ_N - 1 - k));
    logic [efnf_pkg::RT_W-1:0] n_d [LN];
    logic [efnf_pkg::RT_W-1:0] r_d [LN];
    always_comb begin
      logic [efnf_pkg::RT_W-1:0] n, r;
      for (int l = 0; l < LN; l++) begin
        if (k == 0) begin
          n = efnf_pkg::RT_W'(quo_q[efnf_pkg::DIV_N-1][l]);
          r = '0;
        end else begin
          n = rn_q[(k == 0) ? 0 : k-1][l];
          r = rr_q[(k == 0) ? 0 : k-1][l];
        end
        if (n >= r + BIT) begin
          n_d[l] = n - (r + BIT);
          r_d[l] = (r >> 1) + BIT;
        end else begin
          n_d[l] = n;
          r_d[l] = r >> 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < LN; l++) begin
          rn_q[k][l] <= n_d[l];
          rr_q[k][l] <= r_d[l];
        end
      end
    end
  end

  // Round half up, clamp to one, restore sign, catch the zero vector
  always_comb begin
    logic [efnf_pkg::RT_W-1:0]  rt;
    logic [efnf_pkg::ATT_W-1:0] m;
    for (int l = 0; l < LN; l++) begin
      rt = (rr_q[efnf_pkg::SQ_N-1][l] + efnf_pkg::RT_W'(1)) >> 1;
      m  = (rt > efnf_pkg::RT_W'(efnf_pkg::Q14_ONE)) ? efnf_pkg::Q14_ONE
                                                     : rt[efnf_pkg::ATT_W-1:0];
      if (side_q[T-2].zero) begin
        att_d[l] = (l == 0) ? efnf_pkg::Q14_ONE : '0;
      end else begin
        att_d[l] = side_q[T-2].neg[l] ? -m : m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < LN; l++) att_q[l] <= att_d[l];
    end
  end

  // Output word
  assign valid_o      = vld_q[T-1];
  assign pose_valid_o = 1'b1;
  assign ned_north_o  = side_q[T-1].north;
  assign ned_east_o   = side_q[T-1].east;
  assign ned_down_o   = side_q[T-1].down;
  assign att_w_out_o  = att_q[0];
  assign att_x_out_o  = att_q[1];
  assign att_y_out_o  = att_q[2];
  assign att_z_out_o  = att_q[3];
endmodule
`default_nettype wire

FILE: src/enu_flu_to_ned_frd_pose_core_chk.sv
// Port-level checker for the pose converter, bound to the top level.
`default_nettype none
module efnf_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic        pose_valid_o,
  input wire logic [15:0] att_w_out_o,
  input wire logic [15:0] att_x_out_o
);
  // A waiting output word holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(att_w_out_o) && $stable(att_x_out_o))
    else $error("output word changed under stall");

  // Input stall only when an output word is held
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output backpressure");

  // Scalar part is in 0..16384
  a_wpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !att_w_out_o[15] && att_w_out_o <= 16'd16384)
    else $error("scalar part out of range");

  // Pose flag always set
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> pose_valid_o)
    else $error("pose flag clear");
endmodule

bind enu_flu_to_ned_frd_pose_core efnf_chk u_efnf_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .stall_o      (stall_o),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .pose_valid_o (pose_valid_o),
  .att_w_out_o  (att_w_out_o),
  .att_x_out_o  (att_x_out_o)
);
`default_nettype wire

FILE: bench/efnf_pose_checker.sv
// Pose converter checker: predicts the NED/FRD pose for each word taken and compares results.
module efnf_pose_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       stall_o,
  input  logic [efnf_pkg::POS_W-1:0] pos_east_i,
  input  logic [efnf_pkg::POS_W-1:0] pos_north_i,
  input  logic [efnf_pkg::POS_W-1:0] pos_up_i,
  input  logic [efnf_pkg::ATT_W-1:0] att_w_in_i,
  input  logic [efnf_pkg::ATT_W-1:0] att_x_in_i,
  input  logic [efnf_pkg::ATT_W-1:0] att_y_in_i,
  input  logic [efnf_pkg::ATT_W-1:0] att_z_in_i,
  input  logic                       valid_o,
  input  logic                       stall_i,
  input  logic                       pose_valid_o,
  input  logic [efnf_pkg::POS_W-1:0] ned_north_o,
  input  logic [efnf_pkg::POS_W-1:0] ned_east_o,
  input  logic [efnf_pkg::POS_W-1:0] ned_down_o,
  input  logic [efnf_pkg::ATT_W-1:0] att_w_out_o,
  input  logic [efnf_pkg::ATT_W-1:0] att_x_out_o,
  input  logic [efnf_pkg::ATT_W-1:0] att_y_out_o,
  input  logic [efnf_pkg::ATT_W-1:0] att_z_out_o,
  output int                         fail_cnt_o,
  output int                         pending_o,
  output int                         seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                       pvalid;
    logic [efnf_pkg::POS_W-1:0] north;
    logic [efnf_pkg::POS_W-1:0] east;
    logic [efnf_pkg::POS_W-1:0] down;
    logic [efnf_pkg::ATT_W-1:0] quat [efnf_pkg::LANES];
  } ned_pose_t;

  ned_pose_t ned_pose_q[$];

  // Bitwise integer square root, floor.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale one magnitude to Q2.14 of the unit vector, round half up.
  function automatic longint unsigned unit_mag(longint unsigned mag, longint unsigned sum_sq);
    longint unsigned big;
    longint unsigned q;
    big = mag * 16384;
    q = (floor_root((4 * big * big) / sum_sq) + 1) / 2;
    return (q > 16384) ? 16384 : q;
  endfunction

  function automatic ned_pose_t convert_pose(logic [efnf_pkg::POS_W-1:0] pe, pn, pu,
                                             logic [efnf_pkg::ATT_W-1:0] qw, qx, qy, qz);
    ned_pose_t res;
    longint w, x, y, z, dn;
    longint v [efnf_pkg::LANES];
    longint unsigned sum_sq, a, q;
    w = longint'($signed(qw));
    x = longint'($signed(qx));
    y = longint'($signed(qy));
    z = longint'($signed(qz));
    dn = -longint'($signed(pu));
    if (dn > 64'sd2147483647) dn = 64'sd2147483647;
    res.pvalid = 1'b1;
    res.north = pn;
    res.east = pe;
    res.down = dn[efnf_pkg::POS_W-1:0];
    v[0] = -(w + z);
    v[1] = -(x + y);
    v[2] = y - x;
    v[3] = z - w;
    // keep the scalar part non-negative
    if (v[0] < 0) for (int i = 0; i < efnf_pkg::LANES; i++) v[i] = -v[i];
    sum_sq = 0;
    for (int i = 0; i < efnf_pkg::LANES; i++) begin
      a = (v[i] < 0) ? -v[i] : v[i];
      sum_sq += a * a;
    end
    if (sum_sq == 0) begin
      // degenerate attitude falls back to identity
      res.quat[0] = efnf_pkg::Q14_ONE;
      for (int i = 1; i < efnf_pkg::LANES; i++) res.quat[i] = '0;
    end else begin
      for (int i = 0; i < efnf_pkg::LANES; i++) begin
        a = (v[i] < 0) ? -v[i] : v[i];
        q = unit_mag(a, sum_sq);
        res.quat[i] = (v[i] < 0) ? efnf_pkg::ATT_W'(-q) : efnf_pkg::ATT_W'(q);
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [efnf_pkg::POS_W-1:0] exp_v,
                             logic [efnf_pkg::POS_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_cnt_o++;
      $display("%t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_cnt_o = 0;
    seen_o = 0;
    pending_o = 0;
  end

  // Predict on the input side, compare on the output side.
  always @(posedge clk_i) begin
    ned_pose_t exp_p;
    if (rst_ni && valid_i && !stall_o)
      ned_pose_q.push_back(convert_pose(pos_east_i, pos_north_i, pos_up_i,
                                        att_w_in_i, att_x_in_i, att_y_in_i, att_z_in_i));
    if (rst_ni && valid_o && !stall_i) begin
      seen_o++;
      if (ned_pose_q.size() == 0) begin
        fail_cnt_o++;
        $display("%t unexpected word: north %h east %h down %h", $realtime,
                 ned_north_o, ned_east_o, ned_down_o);
      end else begin
        exp_p = ned_pose_q.pop_front();
        check_field("pose_valid", 32'(exp_p.pvalid), 32'(pose_valid_o));
        check_field("ned_north", exp_p.north, ned_north_o);
        check_field("ned_east", exp_p.east, ned_east_o);
        check_field("ned_down", exp_p.down, ned_down_o);
        check_field("att_w_out", 32'(exp_p.quat[0]), 32'(att_w_out_o));
        check_field("att_x_out", 32'(exp_p.quat[1]), 32'(att_x_out_o));
        check_field("att_y_out", 32'(exp_p.quat[2]), 32'(att_y_out_o));
        check_field("att_z_out", 32'(exp_p.quat[3]), 32'(att_z_out_o));
      end
    end
    pending_o = ned_pose_q.size();
  end
endmodule

FILE: bench/enu_flu_to_ned_frd_pose_core_test.sv
// Top of the pose converter bench: clock, reset, stimulus, watchdog and verdict.
module enu_flu_to_ned_frd_pose_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 51;
  localparam int IDLE_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, pose_valid_o;
  logic [efnf_pkg::POS_W-1:0] pos_east_i = '0, pos_north_i = '0, pos_up_i = '0;
  logic [efnf_pkg::ATT_W-1:0] att_w_in_i = '0, att_x_in_i = '0, att_y_in_i = '0;
  logic [efnf_pkg::ATT_W-1:0] att_z_in_i = '0;
  logic [efnf_pkg::POS_W-1:0] ned_north_o, ned_east_o, ned_down_o;
  logic [efnf_pkg::ATT_W-1:0] att_w_out_o, att_x_out_o, att_y_out_o, att_z_out_o;
  int fail_cnt, pending, seen;
  int tx_idle_pct = 0, rx_stall_pct = 0, hold_cnt = 0, idle_cycles = 0, sent = 0;

  enu_flu_to_ned_frd_pose_core u_dut (.*);

  efnf_pose_checker u_chk (
    .fail_cnt_o(fail_cnt), .pending_o(pending), .seen_o(seen), .*
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result side at random, or hold it off for a counted stretch.
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      stall_i <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog on cycles where no word moves on either side.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one word after a random gap and hold it until taken.
  task automatic send_pose(logic [31:0] pe, pn, pu, logic [15:0] w, x, y, z);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    pos_east_i <= pe;
    pos_north_i <= pn;
    pos_up_i <= pu;
    att_w_in_i <= w;
    att_x_in_i <= x;
    att_y_in_i <= y;
    att_z_in_i <= z;
    do @(posedge clk_i); while (stall_o);
    sent++;
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  // Attitudes: mostly components in -16384..16384, some tiny, some full-range noise.
  task automatic send_random_pose();
    logic [15:0] q [4];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      if (kind < 6) q[i] = 16'($signed($urandom_range(32768)) - 16384);
      else if (kind < 8) q[i] = 16'($signed($urandom_range(6)) - 3);
      else q[i] = $urandom;
    end
    send_pose($urandom, $urandom, ($urandom_range(15) == 0) ? 32'h8000_0000 : $urandom,
              q[0], q[1], q[2], q[3]);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: position extremes, zero and identity attitudes, quaternion extremes.
    send_pose(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'd16384, 16'd0, 16'd0, 16'd0);
    send_pose(32'd0, 32'd0, 32'd0, 16'hc000, 16'd0, 16'd0, 16'd0);
    send_pose(32'hffff_ffff, 32'd1, 32'hffff_ffff, 16'd0, 16'd16384, 16'd0, 16'd0);
    send_pose(32'd1, 32'hffff_ffff, 32'd1, 16'd0, 16'd0, 16'd16384, 16'd0);
    send_pose(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'd0, 16'd0, 16'd0, 16'd16384);
    send_pose($urandom, $urandom, $urandom, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pose($urandom, $urandom, $urandom, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pose($urandom, $urandom, $urandom, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_pose($urandom, $urandom, $urandom, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_pose($urandom, $urandom, $urandom, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_pose($urandom, $urandom, $urandom, 16'd1, 16'd0, 16'd0, 16'hffff);
    send_pose($urandom, $urandom, $urandom, 16'd1, 16'd1, 16'd0, 16'd0);
    send_pose($urandom, $urandom, $urandom, 16'd11585, 16'd0, 16'd0, 16'd11585);
    send_pose($urandom, $urandom, $urandom, 16'd8192, 16'd8192, 16'd8192, 16'd8192);
    send_pose($urandom, $urandom, $urandom, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

    // Sender pauses until every result is back.
    drain();

    // Phase one: sender idles lightly, receiver heavily.
    tx_idle_pct = 24;
    rx_stall_pct = 48;
    repeat (180) send_random_pose();
    drain();

    // Phase two: the other way round, with a long receiver hold-off.
    tx_idle_pct = 48;
    rx_stall_pct = 24;
    repeat (180) send_random_pose();
    tx_idle_pct = 0;
    hold_cnt = 300;
    repeat (120) send_random_pose();

    // Phase three: no idling on either side.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (70) send_random_pose();
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d pose words, %0d results checked, under mixed idling and a long hold-off.",
             sent, seen);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_cnt, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
